[hdl/nlas_pkg.sv]
`timescale 1ns / 1ps
package nlas_pkg;
	localparam int FRAC_BITS = 60;
	localparam int X_W = 48;
	localparam int OUT_W = 57;
	localparam int CNT_W = 25;
	localparam int SUM_W = 96;
	localparam int ADDR_W = 2;
	localparam logic [CNT_W-1:0] TERM_COUNT_RESET = 25'd10000000;
	localparam logic [ADDR_W-1:0] REG_TERM_COUNT = 2'd0;
	localparam logic [X_W-1:0] ONE_Q16 = 48'h10000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RATIO, ST_SQUARE, ST_SQUARE_END, ST_CHECK, ST_DIVIDE, ST_MULT, ST_ACC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic ratio_step;
		logic square_step;
		logic save_square;
		logic div_start;
		logic div_step;
		logic mul_step;
		logic accumulate;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic x_zero;
		logic steps_done;
		logic term_small;
		logic terms_done;
	} dp_stat_t;
endpackage

[hdl/nlas_datapath.sv]
`timescale 1ns / 1ps
module nlas_datapath
	import nlas_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	input  logic [X_W-1:0]          x_value,
	input  logic [CNT_W-1:0]        term_count,
	output dp_stat_t                stat,
	output logic signed [OUT_W-1:0] ln_value
);
	// All multi-step work uses one 7-bit step counter: 60 for the ratio divide,
	// 64 for a shift-add product, 64 for a term divide.
	logic [6:0]  step_q;
	logic        neg_q;
	logic [63:0] den_q, rem_q, quo_q;
	logic [63:0] ysq_q, pow_q;
	logic [127:0] prod_q;
	logic [63:0] mcand_q, mplier_q;
	logic [CNT_W-1:0] k_q;
	logic [63:0] n_val;
	logic signed [SUM_W-1:0] sum_q;
	logic [64:0] rsh;
	logic [64:0] trial;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] scaled;

	assign n_val = {38'd0, k_q, 1'b1};
	assign rsh = {rem_q, quo_q[63]};
	assign trial = rsh - {1'b0, (cmd.div_step ? n_val : den_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.load || cmd.div_start || (cmd.square_step && step_q == 7'd60)
				|| (cmd.div_step && step_q == 7'd63)) begin
				step_q <= '0;
			end else if (cmd.ratio_step || cmd.square_step || cmd.div_step || cmd.mul_step) begin
				step_q <= step_q + 7'd1;
			end
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.accumulate) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= x_value < ONE_Q16;
			rem_q <= (x_value < ONE_Q16) ? {16'd0, ONE_Q16 - x_value} : {16'd0, x_value - ONE_Q16};
			den_q <= {16'd0, x_value} + {16'd0, ONE_Q16};
			quo_q <= '0;
			sum_q <= '0;
		end
		if (cmd.ratio_step) begin
			// Restoring divide, quotient shifts in at the bottom.
			if ({rem_q, 1'b0} >= {1'b0, den_q}) begin
				rem_q <= {rem_q[62:0], 1'b0} - den_q;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], 1'b0};
			end
			if (step_q == 7'd59) begin
				mcand_q <= '0;
			end
		end
		if (cmd.square_step) begin
			if (step_q == 7'd60) begin
				pow_q <= quo_q;
				mcand_q <= quo_q;
				mplier_q <= quo_q;
				prod_q <= '0;
			end
		end
		if (cmd.mul_step) begin
			// Shift-add multiply, multiplier consumed from the top bit.
			prod_q <= {prod_q[126:0], 1'b0} + (mplier_q[63] ? {64'd0, mcand_q} : 128'd0);
			mplier_q <= {mplier_q[62:0], 1'b0};
		end
		if (cmd.save_square) begin
			ysq_q <= prod_q[FRAC_BITS +: 64];
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= pow_q;
		end
		if (cmd.div_step) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rsh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
			if (step_q == 7'd63) begin
				mcand_q <= pow_q;
				mplier_q <= ysq_q;
				prod_q <= '0;
			end
		end
		if (cmd.accumulate) begin
			sum_q <= neg_q ? sum_q - $signed({32'd0, quo_q}) : sum_q + $signed({32'd0, quo_q});
			pow_q <= prod_q[FRAC_BITS +: 64];
		end
	end

	// Squaring reuses the multiply path: y*y starts once ST_SQUARE has loaded y as both operands.
	assign stat.steps_done = (cmd.ratio_step && step_q == 7'd59)
		|| (cmd.div_step && step_q == 7'd63) || (cmd.mul_step && step_q == 7'd63);
	assign stat.x_zero = (x_value == '0);
	assign stat.term_small = pow_q < n_val;
	assign stat.terms_done = {1'b0, k_q} >= {1'b0, term_count};

	always_comb begin
		mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		scaled = mag >> (FRAC_BITS - 49);
		if (cmd.finish && stat.x_zero) begin
			ln_value = {1'b1, {(OUT_W-1){1'b0}}};
		end else if (sum_q[SUM_W-1]) begin
			ln_value = (scaled > {{(SUM_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}})
				? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-scaled);
		end else begin
			ln_value = (scaled > {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}})
				? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(scaled);
		end
	end
endmodule

[hdl/nlas_ctrl.sv]
`timescale 1ns / 1ps
module nlas_ctrl
	import nlas_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     x_zero,
	input  dp_stat_t stat,
	input  logic     out_free,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     capture,
	output logic     zero_result
);
	state_t state_q, state_d;
	logic sq_q, zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sq_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				zero_q <= x_zero;
				sq_q <= 1'b1;
			end else if (state_q == ST_MULT && stat.steps_done) begin
				sq_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		capture = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = x_zero ? ST_FINISH : ST_RATIO;
				end
			end
			ST_RATIO: begin
				cmd.ratio_step = 1'b1;
				if (stat.steps_done) state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square_step = 1'b1;
				state_d = ST_MULT;
			end
			ST_SQUARE_END: begin
				cmd.save_square = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.terms_done || stat.term_small) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.steps_done) state_d = ST_MULT;
			end
			ST_MULT: begin
				cmd.mul_step = 1'b1;
				if (stat.steps_done) state_d = sq_q ? ST_SQUARE_END : ST_ACC;
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_d = ST_CHECK;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (out_free) begin
					capture = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign zero_result = zero_q;
endmodule

[hdl/natural_log_atanh_series_top.sv]
`timescale 1ns / 1ps
// Natural logarithm by the atanh series. Each beat on the s_t* side carries an argument x in
// unsigned Q32.16, and one beat on the m_t* side later carries ln(x) in signed Q8.48, zero
// filled to 64 bits and saturated; a zero argument gives the most negative value. The APB
// register at address 0 holds term_count, the number of series terms (reset 10000000); the
// user must write it only while no beat is in flight, as the block itself does not enforce
// this. The block works on one argument at a time. The number of terms actually summed is
// the lesser of term_count and the index at which the terms become zero. The work runs as the
// ratio divide, squaring the ratio, then each term (a divide, a multiply and the bookkeeping
// states ST_CHECK and ST_ACC) and the finish; a zero argument skips straight to the finish.
// The result waits in an output register, so the block takes the next argument in the cycle
// after a result is captured and stalls before its own capture only while that register is
// still full.
module natural_log_atanh_series_top
	import nlas_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [X_W-1:0]          s_tdata, // x_value
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [63:0]             m_tdata  // ln_value, zero filled
);
	logic [CNT_W-1:0] term_count_q;
	logic [X_W-1:0] x_q;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic busy, capture, zero_result;
	logic signed [OUT_W-1:0] ln_w;
	logic [OUT_W-1:0] res_q;
	logic valid_q;
	logic in_fire;

	// The register file has a single entry and never waits.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_TERM_COUNT) ? {7'd0, term_count_q} : 32'd0;

	// A new argument is taken only while the controller is idle.
	assign in_fire = s_tvalid && s_tready;
	assign s_tready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RESET;
			valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_TERM_COUNT)
				term_count_q <= pwdata[CNT_W-1:0];
			if (capture) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	// The argument is held for the whole series, and the result is held until taken.
	always_ff @(posedge clk) begin
		if (in_fire) x_q <= s_tdata;
		if (capture) res_q <= zero_result ? {1'b1, {(OUT_W-1){1'b0}}} : ln_w;
	end

	nlas_datapath u_dp (.clk, .arst_n, .cmd, .x_value(in_fire ? s_tdata : x_q),
		.term_count(term_count_q), .stat, .ln_value(ln_w));
	nlas_ctrl u_ctrl (.clk, .arst_n, .in_fire, .x_zero(s_tdata == '0), .stat,
		.out_free(!valid_q || m_tready), .cmd, .busy, .capture, .zero_result);

	assign m_tvalid = valid_q;
	assign m_tdata = {{(64-OUT_W){1'b0}}, res_q};

`ifndef SYNTHESIS
	// A waiting result beat stays up and unchanged until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	// A new result is captured only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> (!valid_q || m_tready));
	// The padding above the result is always zero.
	assert property (@(posedge clk) m_tdata[63:OUT_W] == '0);
`endif
endmodule
